FILE: design/sfeg_pkg.sv
// ----------------------------------------------------------------------------
// sfeg_pkg
// Shared types, constants and saturating helpers for the SVI fit error and
// gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfeg_pkg;

  // Fixed-point format of inputs and intermediates, and the Q32.32 shift
  localparam int FRAC_BITS = 28;
  localparam int QSH       = 2 * FRAC_BITS - 32;

  // Input queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Config port address width (six 32-bit registers at 4*i)
  localparam int ADDR_W = 5;

  // Sequential unit lengths
  localparam int MUL_LAST = 5;             // multiplier: four partial products
  localparam int DIV_BITS = 64;            // divider: one quotient bit a cycle
  localparam int SQ_PRE   = 3;             // root: two squares and a sum
  localparam int SQ_LAST  = SQ_PRE + 32 - 1;

  typedef logic signed [63:0] s64_t;

  localparam s64_t S64_MAX = {1'b0, {63{1'b1}}};
  localparam s64_t S64_MIN = {1'b1, 63'd0};

  // Register map index
  typedef enum logic [2:0] {
    REG_SLOPE_B   = 3'd0,
    REG_SKEW_RHO  = 3'd1,
    REG_SHIFT_M   = 3'd2,
    REG_SIGMA     = 3'd3,
    REG_ATM_VAR   = 3'd4,
    REG_WANT_GRAD = 3'd5
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic        [30:0] b;
    logic signed [29:0] rho;
    logic signed [31:0] m;
    logic        [30:0] sig;
    logic        [30:0] atm;
    logic               grad;
  } cfg_t;

  // One queued point; xi = k - m is formed on entry
  typedef struct packed {
    logic signed [31:0] k;
    logic signed [31:0] wm;
    logic signed [32:0] xi;
    logic               last;
  } item_t;

  typedef struct packed {
    logic start;
    s64_t a;
    s64_t b;
    logic qsh;
  } mul_req_t;

  typedef struct packed {
    logic done;
    s64_t res;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] x;
    logic        [30:0] s;
  } sq_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sq_rsp_t;

  // Back-end sequencer
  typedef enum logic [4:0] {
    S_IDLE, S_R0, S_RR, S_C0, S_BRHO, S_WK1, S_WK2, S_RES, S_SSE,
    S_R2B, S_TB, S_TB2, S_Q1, S_Q2, S_INV_R, S_INV_R0, S_BS, S_R2BS,
    S_GB, S_GRHO, S_GM, S_GS, S_EMIT
  } back_state_t;

  function automatic s64_t sat_add(s64_t a, s64_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s64_t'(s[63:0]);
  endfunction

  function automatic s64_t sat_sub(s64_t a, s64_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s64_t'(s[63:0]);
  endfunction

  function automatic logic [63:0] mag64(s64_t a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  // Apply a sign to a magnitude, saturating to the int64 range
  function automatic s64_t from_mag(logic neg, logic [63:0] u);
    if (neg) begin
      if (u[63]) return S64_MIN;
      return s64_t'(64'd0 - u);
    end
    if (u[63]) return S64_MAX;
    return s64_t'(u);
  endfunction

  function automatic s64_t neg_sat(s64_t a);
    return from_mag(!a[63], mag64(a));
  endfunction

endpackage

`default_nettype wire

FILE: design/sfeg_front.sv
// ----------------------------------------------------------------------------
// sfeg_front
// Accepts points, forms the offset k - m and holds them in a short queue for
// the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sfeg_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic signed [31:0] log_moneyness,
  input  wire logic signed [31:0] market_variance,
  input  wire logic               last_point,
  input  wire logic signed [31:0] shift_m,
  output logic                    full,
  input  wire logic               q_pop,
  output sfeg_pkg::item_t         q_item,
  output logic                    q_empty
);

  sfeg_pkg::item_t           mem_r [sfeg_pkg::Q_DEPTH];
  logic [sfeg_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [sfeg_pkg::Q_AW:0]   cnt_r;
  logic                      wr_en, rd_en;
  sfeg_pkg::item_t           entry;

  assign full    = (cnt_r == (sfeg_pkg::Q_AW+1)'(sfeg_pkg::Q_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && !q_empty;
  assign q_item  = mem_r[rd_ptr_r];

  // Form the queue entry: offset from the smile center
  always_comb begin
    entry.k    = log_moneyness;
    entry.wm   = market_variance;
    entry.xi   = {log_moneyness[31], log_moneyness} - {shift_m[31], shift_m};
    entry.last = last_point;
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= entry;
  end

endmodule

`default_nettype wire

FILE: design/sfeg_mul.sv
// ----------------------------------------------------------------------------
// sfeg_mul
// Signed 64x64 multiply, shifted right by FRAC_BITS or QSH with truncation
// toward zero and int64 saturation. One 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfeg_mul (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sfeg_pkg::mul_req_t req,
  output sfeg_pkg::mul_rsp_t      rsp
);

  logic                busy_r, done_r, neg_r, qsh_r;
  logic [2:0]          cnt_r;
  logic [63:0]         ua_r, ub_r, pp_r;
  logic [127:0]        acc_r, pp_ext, shifted;
  logic [31:0]         opa, opb;
  logic [63:0]         prod, lo;
  sfeg_pkg::s64_t      res_r;

  // Partial product select
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: begin opa = ua_r[31:0];  opb = ub_r[31:0];  end
      2'd1: begin opa = ua_r[31:0];  opb = ub_r[63:32]; end
      2'd2: begin opa = ua_r[63:32]; opb = ub_r[31:0];  end
      default: begin opa = ua_r[63:32]; opb = ub_r[63:32]; end
    endcase
  end
  assign prod = 64'(opa) * 64'(opb);

  // Alignment of the registered partial product (added in the cycle after it is formed)
  always_comb begin
    unique case (cnt_r)
      3'd1:    pp_ext = {64'd0, pp_r};
      3'd2,
      3'd3:    pp_ext = {32'd0, pp_r, 32'd0};
      3'd4:    pp_ext = {pp_r, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  // Scale, then clamp anything above 64 bits
  assign shifted = qsh_r ? (acc_r >> sfeg_pkg::QSH) : (acc_r >> sfeg_pkg::FRAC_BITS);
  assign lo      = (|shifted[127:64]) ? '1 : shifted[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'(sfeg_pkg::MUL_LAST)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (req.start) begin
        ua_r  <= sfeg_pkg::mag64(req.a);
        ub_r  <= sfeg_pkg::mag64(req.b);
        neg_r <= req.a[63] ^ req.b[63];
        qsh_r <= req.qsh;
        acc_r <= '0;
      end
    end else begin
      if (cnt_r <= 3'd3) pp_r <= prod;
      acc_r <= acc_r + pp_ext;
      if (cnt_r == 3'(sfeg_pkg::MUL_LAST)) res_r <= sfeg_pkg::from_mag(neg_r, lo);
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

`default_nettype wire

FILE: design/sfeg_div.sv
// ----------------------------------------------------------------------------
// sfeg_div
// Unsigned 64-by-32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfeg_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sfeg_pkg::div_req_t req,
  output sfeg_pkg::div_rsp_t      rsp
);

  localparam int CW = $clog2(sfeg_pkg::DIV_BITS);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [31:0]   rem_r, den_r;
  logic [63:0]   quo_r;
  logic [32:0]   trial, diff;
  logic          qbit;

  // Shift in the next dividend bit, subtract when it fits
  assign trial = {rem_r, quo_r[63]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = !diff[32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(sfeg_pkg::DIV_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (req.start) begin
        rem_r <= '0;
        quo_r <= req.num;
        den_r <= req.den;
      end
    end else begin
      rem_r <= qbit ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[62:0], qbit};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

FILE: design/sfeg_sqrt.sv
// ----------------------------------------------------------------------------
// sfeg_sqrt
// Radius floor(sqrt(min(x^2,...) + s^2)) with |x| clipped to 32 bits and the
// sum saturated to 64 bits. Two squares, one sum, then one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfeg_sqrt (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sfeg_pkg::sq_req_t req,
  output sfeg_pkg::sq_rsp_t      rsp
);

  logic        busy_r, done_r;
  logic [5:0]  ph_r;
  logic [31:0] ux_r, s_r, root_r, mopa;
  logic [63:0] p_r, v_r, prod;
  logic [34:0] rem_r, rem_t, trial, diff;
  logic [64:0] vsum;
  logic [32:0] ax;
  logic [31:0] ux;

  // Clip |x| to 32 bits
  assign ax = req.x[32] ? (33'd0 - req.x) : req.x;
  assign ux = ax[32] ? '1 : ax[31:0];

  // One squarer shared by both terms
  assign mopa = (ph_r == 6'd0) ? ux_r : s_r;
  assign prod = 64'(mopa) * 64'(mopa);
  assign vsum = {1'b0, v_r} + {1'b0, p_r};

  // Digit recurrence: two radicand bits per root bit
  assign rem_t = {rem_r[32:0], v_r[63:62]};
  assign trial = {1'b0, root_r, 2'b01};
  assign diff  = rem_t - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          ph_r   <= '0;
        end
      end else begin
        ph_r <= ph_r + 6'd1;
        if (ph_r == 6'(sfeg_pkg::SQ_LAST)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r) begin
      if (req.start) begin
        ux_r <= ux;
        s_r  <= {1'b0, req.s};
      end
    end else begin
      if (ph_r == 6'd0) begin
        p_r <= prod;
      end else if (ph_r == 6'd1) begin
        v_r <= p_r;
        p_r <= prod;
      end else if (ph_r == 6'd2) begin
        v_r    <= vsum[64] ? '1 : vsum[63:0];
        rem_r  <= '0;
        root_r <= '0;
      end else begin
        v_r <= {v_r[61:0], 2'b00};
        if (!diff[34]) begin
          rem_r  <= diff;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_t;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

`default_nettype wire

FILE: design/sfeg_back.sv
// ----------------------------------------------------------------------------
// sfeg_back
// Sequencer that takes one queued point at a time through the shared
// multiplier, divider and root units, keeps the saturating sums and holds
// the finished totals in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfeg_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sfeg_pkg::cfg_t     cfg,
  input  wire logic               q_empty,
  input  wire sfeg_pkg::item_t    q_item,
  output logic                    q_pop,
  output sfeg_pkg::mul_req_t      mul_req,
  input  wire sfeg_pkg::mul_rsp_t mul_rsp,
  output sfeg_pkg::div_req_t      div_req,
  input  wire sfeg_pkg::div_rsp_t div_rsp,
  output sfeg_pkg::sq_req_t       sq_req,
  input  wire sfeg_pkg::sq_rsp_t  sq_rsp,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output logic [62:0]             sum_sq_error,
  output sfeg_pkg::s64_t          grad_b,
  output sfeg_pkg::s64_t          grad_rho,
  output sfeg_pkg::s64_t          grad_m,
  output sfeg_pkg::s64_t          grad_sigma
);

  sfeg_pkg::back_state_t state_r, state_nxt;
  logic                  issued_r, issued_nxt;
  logic                  mul_go, div_go, sq_go, mul_qsh, unit_done;
  sfeg_pkg::s64_t        mul_a, mul_b;
  logic [63:0]           div_num;
  logic [31:0]           div_den;
  logic signed [32:0]    sq_x;

  // Point under work and intermediates
  logic signed [31:0]    k_r, wm_r;
  logic signed [32:0]    xi_r;
  logic                  last_r;
  logic [31:0]           r0_r, rr_r;
  sfeg_pkg::s64_t        c0_r, brho_r, wk_r, r_r, r2_r, r2b_r, tb_r, tm_r;
  sfeg_pkg::s64_t        invr_r, invr0_r, bs_r, r2bs_r;

  // Sums and result register
  sfeg_pkg::s64_t        sse_acc_r, gb_acc_r, grho_acc_r, gm_acc_r, gs_acc_r;
  logic                  out_valid_r;
  sfeg_pkg::s64_t        out_sse_r, out_gb_r, out_grho_r, out_gm_r, out_gs_r;

  // Operands widened to int64
  logic [30:0]           sig_used;
  sfeg_pkg::s64_t        b64, rho64, sig64, atm64, k64, wm64, r0_64, rr64;
  logic [31:0]           m_mag;
  logic [32:0]           xi_mag;
  logic                  emit;

  assign sig_used = (cfg.sig == '0) ? 31'd1 : cfg.sig;
  assign b64      = {33'd0, cfg.b};
  assign rho64    = {{34{cfg.rho[29]}}, cfg.rho};
  assign sig64    = {33'd0, sig_used};
  assign atm64    = {33'd0, cfg.atm};
  assign k64      = {{32{k_r[31]}}, k_r};
  assign wm64     = {{32{wm_r[31]}}, wm_r};
  assign r0_64    = {32'd0, r0_r};
  assign rr64     = {32'd0, rr_r};
  assign m_mag    = cfg.m[31] ? (32'd0 - cfg.m) : cfg.m;
  assign xi_mag   = xi_r[32] ? (33'd0 - xi_r) : xi_r;

  assign unit_done = mul_rsp.done | div_rsp.done | sq_rsp.done;
  assign emit      = (state_r == sfeg_pkg::S_EMIT) && !out_valid_r;

  // Sequencer: next state and unit requests
  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    q_pop      = 1'b0;
    mul_go     = 1'b0;
    div_go     = 1'b0;
    sq_go      = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    mul_qsh    = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sq_x       = '0;
    unique case (state_r)
      sfeg_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = sfeg_pkg::S_R0;
        end
      end
      sfeg_pkg::S_R0: begin
        sq_go = !issued_r;
        sq_x  = {cfg.m[31], cfg.m};
        if (unit_done) state_nxt = sfeg_pkg::S_RR;
      end
      sfeg_pkg::S_RR: begin
        sq_go = !issued_r;
        sq_x  = xi_r;
        if (unit_done) state_nxt = sfeg_pkg::S_C0;
      end
      sfeg_pkg::S_C0: begin
        mul_go = !issued_r; mul_a = b64; mul_b = r0_64;
        if (unit_done) state_nxt = sfeg_pkg::S_BRHO;
      end
      sfeg_pkg::S_BRHO: begin
        mul_go = !issued_r; mul_a = b64; mul_b = rho64;
        if (unit_done) state_nxt = sfeg_pkg::S_WK1;
      end
      sfeg_pkg::S_WK1: begin
        mul_go = !issued_r; mul_a = brho_r; mul_b = k64;
        if (unit_done) state_nxt = sfeg_pkg::S_WK2;
      end
      sfeg_pkg::S_WK2: begin
        mul_go = !issued_r; mul_a = b64; mul_b = rr64;
        if (unit_done) state_nxt = sfeg_pkg::S_RES;
      end
      sfeg_pkg::S_RES: state_nxt = sfeg_pkg::S_SSE;
      sfeg_pkg::S_SSE: begin
        mul_go = !issued_r; mul_a = r_r; mul_b = r_r; mul_qsh = 1'b1;
        if (unit_done) begin
          if (cfg.grad) state_nxt = sfeg_pkg::S_R2B;
          else if (last_r) state_nxt = sfeg_pkg::S_EMIT;
          else state_nxt = sfeg_pkg::S_IDLE;
        end
      end
      sfeg_pkg::S_R2B: begin
        mul_go = !issued_r; mul_a = r2_r; mul_b = b64;
        if (unit_done) state_nxt = sfeg_pkg::S_TB;
      end
      sfeg_pkg::S_TB: begin
        mul_go = !issued_r; mul_a = rho64; mul_b = k64;
        if (unit_done) state_nxt = sfeg_pkg::S_TB2;
      end
      sfeg_pkg::S_TB2: state_nxt = sfeg_pkg::S_Q1;
      sfeg_pkg::S_Q1: begin
        div_go  = !issued_r;
        div_num = 64'(m_mag) << sfeg_pkg::FRAC_BITS;
        div_den = r0_r;
        if (unit_done) state_nxt = sfeg_pkg::S_Q2;
      end
      sfeg_pkg::S_Q2: begin
        div_go  = !issued_r;
        div_num = 64'(xi_mag) << sfeg_pkg::FRAC_BITS;
        div_den = rr_r;
        if (unit_done) state_nxt = sfeg_pkg::S_INV_R;
      end
      sfeg_pkg::S_INV_R: begin
        div_go  = !issued_r;
        div_num = 64'd1 << (2 * sfeg_pkg::FRAC_BITS);
        div_den = rr_r;
        if (unit_done) state_nxt = sfeg_pkg::S_INV_R0;
      end
      sfeg_pkg::S_INV_R0: begin
        div_go  = !issued_r;
        div_num = 64'd1 << (2 * sfeg_pkg::FRAC_BITS);
        div_den = r0_r;
        if (unit_done) state_nxt = sfeg_pkg::S_BS;
      end
      sfeg_pkg::S_BS: begin
        mul_go = !issued_r; mul_a = b64; mul_b = sig64;
        if (unit_done) state_nxt = sfeg_pkg::S_R2BS;
      end
      sfeg_pkg::S_R2BS: begin
        mul_go = !issued_r; mul_a = r2_r; mul_b = bs_r;
        if (unit_done) state_nxt = sfeg_pkg::S_GB;
      end
      sfeg_pkg::S_GB: begin
        mul_go = !issued_r; mul_a = r2_r; mul_b = tb_r; mul_qsh = 1'b1;
        if (unit_done) state_nxt = sfeg_pkg::S_GRHO;
      end
      sfeg_pkg::S_GRHO: begin
        mul_go = !issued_r; mul_a = r2b_r; mul_b = k64; mul_qsh = 1'b1;
        if (unit_done) state_nxt = sfeg_pkg::S_GM;
      end
      sfeg_pkg::S_GM: begin
        mul_go = !issued_r; mul_a = r2b_r; mul_b = tm_r; mul_qsh = 1'b1;
        if (unit_done) state_nxt = sfeg_pkg::S_GS;
      end
      sfeg_pkg::S_GS: begin
        mul_go = !issued_r; mul_a = r2bs_r; mul_b = invr_r - invr0_r; mul_qsh = 1'b1;
        if (unit_done) state_nxt = last_r ? sfeg_pkg::S_EMIT : sfeg_pkg::S_IDLE;
      end
      sfeg_pkg::S_EMIT: begin
        if (!out_valid_r) state_nxt = sfeg_pkg::S_IDLE;
      end
      default: state_nxt = sfeg_pkg::S_IDLE;
    endcase
    if (mul_go || div_go || sq_go) issued_nxt = 1'b1;
    if (unit_done) issued_nxt = 1'b0;
  end

  assign mul_req.start = mul_go;
  assign mul_req.a     = mul_a;
  assign mul_req.b     = mul_b;
  assign mul_req.qsh   = mul_qsh;
  assign div_req.start = div_go;
  assign div_req.num   = div_num;
  assign div_req.den   = div_den;
  assign sq_req.start  = sq_go;
  assign sq_req.x      = sq_x;
  assign sq_req.s      = sig_used;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sfeg_pkg::S_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  // Per-point intermediates
  always_ff @(posedge clk) begin
    unique case (state_r)
      sfeg_pkg::S_IDLE: begin
        if (!q_empty) begin
          k_r    <= q_item.k;
          wm_r   <= q_item.wm;
          xi_r   <= q_item.xi;
          last_r <= q_item.last;
        end
      end
      sfeg_pkg::S_R0:   if (sq_rsp.done) r0_r <= sq_rsp.root;
      sfeg_pkg::S_RR:   if (sq_rsp.done) rr_r <= sq_rsp.root;
      sfeg_pkg::S_C0:   if (mul_rsp.done) c0_r <= sfeg_pkg::sat_sub(atm64, mul_rsp.res);
      sfeg_pkg::S_BRHO: if (mul_rsp.done) brho_r <= mul_rsp.res;
      sfeg_pkg::S_WK1:  if (mul_rsp.done) wk_r <= sfeg_pkg::sat_add(c0_r, mul_rsp.res);
      sfeg_pkg::S_WK2:  if (mul_rsp.done) wk_r <= sfeg_pkg::sat_add(wk_r, mul_rsp.res);
      sfeg_pkg::S_RES:  r_r <= sfeg_pkg::sat_sub(wk_r, wm64);
      sfeg_pkg::S_SSE:  if (!issued_r) r2_r <= sfeg_pkg::sat_add(r_r, r_r);
      sfeg_pkg::S_R2B:  if (mul_rsp.done) r2b_r <= mul_rsp.res;
      sfeg_pkg::S_TB:   if (mul_rsp.done) tb_r <= sfeg_pkg::sat_add(mul_rsp.res, rr64);
      sfeg_pkg::S_TB2:  tb_r <= sfeg_pkg::sat_sub(tb_r, r0_64);
      sfeg_pkg::S_Q1:   if (div_rsp.done) tm_r <= sfeg_pkg::from_mag(cfg.m[31], div_rsp.quo);
      sfeg_pkg::S_Q2: begin
        if (div_rsp.done)
          tm_r <= sfeg_pkg::sat_add(tm_r, sfeg_pkg::from_mag(xi_r[32], div_rsp.quo));
      end
      sfeg_pkg::S_INV_R:  if (div_rsp.done) invr_r <= div_rsp.quo;
      sfeg_pkg::S_INV_R0: if (div_rsp.done) invr0_r <= div_rsp.quo;
      sfeg_pkg::S_BS:     if (mul_rsp.done) bs_r <= mul_rsp.res;
      sfeg_pkg::S_R2BS:   if (mul_rsp.done) r2bs_r <= mul_rsp.res;
      default: ;
    endcase
  end

  // Saturating sums; cleared when the totals move to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sse_acc_r  <= '0;
      gb_acc_r   <= '0;
      grho_acc_r <= '0;
      gm_acc_r   <= '0;
      gs_acc_r   <= '0;
    end else if (emit) begin
      sse_acc_r  <= '0;
      gb_acc_r   <= '0;
      grho_acc_r <= '0;
      gm_acc_r   <= '0;
      gs_acc_r   <= '0;
    end else if (mul_rsp.done) begin
      unique case (state_r)
        sfeg_pkg::S_SSE:  sse_acc_r  <= sfeg_pkg::sat_add(sse_acc_r, mul_rsp.res);
        sfeg_pkg::S_GB:   gb_acc_r   <= sfeg_pkg::sat_add(gb_acc_r, mul_rsp.res);
        sfeg_pkg::S_GRHO: grho_acc_r <= sfeg_pkg::sat_add(grho_acc_r, mul_rsp.res);
        sfeg_pkg::S_GM:
          gm_acc_r <= sfeg_pkg::sat_add(gm_acc_r, sfeg_pkg::neg_sat(mul_rsp.res));
        sfeg_pkg::S_GS:   gs_acc_r   <= sfeg_pkg::sat_add(gs_acc_r, mul_rsp.res);
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sse_r  <= sse_acc_r;
      out_gb_r   <= gb_acc_r;
      out_grho_r <= grho_acc_r;
      out_gm_r   <= gm_acc_r;
      out_gs_r   <= gs_acc_r;
    end
  end

  assign out_empty    = !out_valid_r;
  assign sum_sq_error = out_sse_r[62:0];
  assign grad_b       = out_gb_r;
  assign grad_rho     = out_grho_r;
  assign grad_m       = out_gm_r;
  assign grad_sigma   = out_gs_r;

`ifndef ASSERT_OFF
  // A unit answers only while the sequencer waits for it
  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> issued_r)
    else $error("unit result with no request outstanding");

  // Only one shared unit is started at a time
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_go, div_go, sq_go}))
    else $error("two units started together");

  // Moving totals out clears the sums and fills the result register
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && sse_acc_r == '0 && gb_acc_r == '0 && gs_acc_r == '0))
    else $error("totals not moved or sums not cleared");

  // No unit completes while idle or waiting to emit
  a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> (state_r != sfeg_pkg::S_IDLE && state_r != sfeg_pkg::S_EMIT))
    else $error("unit result outside a compute step");
`endif

endmodule

`default_nettype wire

FILE: design/svi_fit_error_and_gradient.sv
// ----------------------------------------------------------------------------
// svi_fit_error_and_gradient
// Least-squares misfit of an SVI smile and its gradient in b, rho, m, sigma.
// ----------------------------------------------------------------------------
// Usage:
//  Points enter on a queue-style port: an item is taken when push is high and
//  full is low; it carries k, market variance and a last flag. A four-deep
//  queue holds points while the back end works on one point at a time.
//  The point marked last yields one result item with the saturated Q32.32
//  totals, and the sums restart from zero. The result waits in an output
//  register on empty/pop; while it is not popped the back end holds at the
//  next last point and the input queue fills until full is raised.
//  Cost per point comes from the shared sequential units, so a point costs
//  more with the gradient on. After the last point's final step the back
//  end moves the totals into the output register in its emit state.
//  Registers sit on an APB-style port at byte address 4*i and are to be
//  written only while the block is idle; the block does not enforce this.
//  Reset restores the defaults (sigma 1.0, gradient on), empties the queue
//  and clears all sums.
// ----------------------------------------------------------------------------
`default_nettype none

module svi_fit_error_and_gradient (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // point input
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [31:0]            in_log_moneyness,
  input  wire logic signed [31:0]            in_market_variance,
  input  wire logic                          in_last_point,
  // result output
  output logic                               empty,
  input  wire logic                          pop,
  output logic [62:0]                        out_sum_sq_error,
  output logic signed [63:0]                 out_grad_b,
  output logic signed [63:0]                 out_grad_rho,
  output logic signed [63:0]                 out_grad_m,
  output logic signed [63:0]                 out_grad_sigma,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sfeg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  sfeg_pkg::cfg_t     cfg_r;
  sfeg_pkg::reg_idx_t idx;
  logic               wr_en;
  logic               q_empty, q_pop, out_pop;
  sfeg_pkg::item_t    q_item;
  sfeg_pkg::mul_req_t mul_req;
  sfeg_pkg::mul_rsp_t mul_rsp;
  sfeg_pkg::div_req_t div_req;
  sfeg_pkg::div_rsp_t div_rsp;
  sfeg_pkg::sq_req_t  sq_req;
  sfeg_pkg::sq_rsp_t  sq_rsp;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign idx     = sfeg_pkg::reg_idx_t'(paddr[4:2]);
  assign out_pop = pop && !empty;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b    <= '0;
      cfg_r.rho  <= '0;
      cfg_r.m    <= '0;
      cfg_r.sig  <= 31'(1) << sfeg_pkg::FRAC_BITS;
      cfg_r.atm  <= '0;
      cfg_r.grad <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        sfeg_pkg::REG_SLOPE_B:   cfg_r.b    <= pwdata[30:0];
        sfeg_pkg::REG_SKEW_RHO:  cfg_r.rho  <= pwdata[29:0];
        sfeg_pkg::REG_SHIFT_M:   cfg_r.m    <= pwdata;
        sfeg_pkg::REG_SIGMA:     cfg_r.sig  <= pwdata[30:0];
        sfeg_pkg::REG_ATM_VAR:   cfg_r.atm  <= pwdata[30:0];
        sfeg_pkg::REG_WANT_GRAD: cfg_r.grad <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (idx)
      sfeg_pkg::REG_SLOPE_B:   prdata = {1'b0, cfg_r.b};
      sfeg_pkg::REG_SKEW_RHO:  prdata = {{2{cfg_r.rho[29]}}, cfg_r.rho};
      sfeg_pkg::REG_SHIFT_M:   prdata = cfg_r.m;
      sfeg_pkg::REG_SIGMA:     prdata = {1'b0, cfg_r.sig};
      sfeg_pkg::REG_ATM_VAR:   prdata = {1'b0, cfg_r.atm};
      sfeg_pkg::REG_WANT_GRAD: prdata = {31'd0, cfg_r.grad};
      default:                 prdata = '0;
    endcase
  end

  sfeg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .log_moneyness   (in_log_moneyness),
    .market_variance (in_market_variance),
    .last_point      (in_last_point),
    .shift_m         (cfg_r.m),
    .full            (full),
    .q_pop           (q_pop),
    .q_item          (q_item),
    .q_empty         (q_empty)
  );

  sfeg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  sfeg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sfeg_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  sfeg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_empty      (q_empty),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .mul_req      (mul_req),
    .mul_rsp      (mul_rsp),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .sq_req       (sq_req),
    .sq_rsp       (sq_rsp),
    .out_empty    (empty),
    .out_pop      (out_pop),
    .sum_sq_error (out_sum_sq_error),
    .grad_b       (out_grad_b),
    .grad_rho     (out_grad_rho),
    .grad_m       (out_grad_m),
    .grad_sigma   (out_grad_sigma)
  );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SVI fit error and gradient block: smiles of
// points go in through the push/full queue port and are predicted by a
// bit-exact fixed-point model of the misfit and its gradient sums, while the
// monitor pops result items and checks them field by field against the
// predicted totals. Registers are changed through the APB port between
// phases, with the block idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HALF_PERIOD = 4;
  localparam int          IDLE_DRAIN  = 700;     // longer than one point with gradient on
  localparam int          STALL_LIMIT = 20000;   // cycles with no handshake at all
  localparam int          LONG_HOLD   = 4000;
  localparam logic [2:0]  REG_SPARE_6 = 3'd6;
  localparam logic [2:0]  REG_SPARE_7 = 3'd7;
  localparam int          NPHASES     = 12;

  typedef struct {
    logic signed [31:0] k;
    logic signed [31:0] wm;
    logic               last;
  } point_t;

  typedef struct {
    logic [62:0]    sse;
    sfeg_pkg::s64_t gb;
    sfeg_pkg::s64_t grho;
    sfeg_pkg::s64_t gm;
    sfeg_pkg::s64_t gs;
  } totals_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               push = 1'b0;
  logic               full;
  logic signed [31:0] in_log_moneyness = '0;
  logic signed [31:0] in_market_variance = '0;
  logic               in_last_point = 1'b0;

  logic               empty;
  logic               pop = 1'b0;
  logic [62:0]        out_sum_sq_error;
  logic signed [63:0] out_grad_b, out_grad_rho, out_grad_m, out_grad_sigma;

  logic                        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [sfeg_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  svi_fit_error_and_gradient u_dut (
    .clk, .rst_n,
    .push, .full, .in_log_moneyness, .in_market_variance, .in_last_point,
    .empty, .pop, .out_sum_sq_error, .out_grad_b, .out_grad_rho, .out_grad_m,
    .out_grad_sigma,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Mirror of the configuration and the running sums
  // --------------------------------------------------------------------------
  logic        [30:0] cur_b;
  logic signed [29:0] cur_rho;
  logic signed [31:0] cur_m;
  logic        [30:0] cur_sig;
  logic        [30:0] cur_atm;
  logic               cur_grad;
  logic        [31:0] cur_r0;
  sfeg_pkg::s64_t     acc_sse, acc_gb, acc_grho, acc_gm, acc_gs;

  point_t  pending_points[$];
  totals_t expected_totals[$];
  int      errors = 0;
  bit      idle_en = 1'b1;
  int      hold_ask = 0;

  function automatic logic [63:0] absval(sfeg_pkg::s64_t a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic sfeg_pkg::s64_t signed_sat(bit neg, logic [63:0] u);
    if (neg) return u[63] ? sfeg_pkg::S64_MIN : sfeg_pkg::s64_t'(64'd0 - u);
    return u[63] ? sfeg_pkg::S64_MAX : sfeg_pkg::s64_t'(u);
  endfunction

  function automatic sfeg_pkg::s64_t qadd(sfeg_pkg::s64_t a, sfeg_pkg::s64_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(sfeg_pkg::S64_MAX)) return sfeg_pkg::S64_MAX;
    if (s < 65'(sfeg_pkg::S64_MIN)) return sfeg_pkg::S64_MIN;
    return sfeg_pkg::s64_t'(s);
  endfunction

  // exact product, shifted toward zero, saturated
  function automatic sfeg_pkg::s64_t qmul(sfeg_pkg::s64_t a, sfeg_pkg::s64_t b, int sh);
    logic [127:0] p;
    logic [63:0]  lo;
    p  = {64'd0, absval(a)} * {64'd0, absval(b)};
    p  = p >> sh;
    lo = (p[127:64] != 0) ? '1 : p[63:0];
    return signed_sat(a[63] ^ b[63], lo);
  endfunction

  function automatic sfeg_pkg::s64_t qdiv(sfeg_pkg::s64_t num, logic [63:0] den);
    logic [63:0] q;
    q = (absval(num) << sfeg_pkg::FRAC_BITS) / den;
    return signed_sat(num[63], q);
  endfunction

  // floor sqrt(x^2 + s^2), clamped to 32 bits
  function automatic logic [31:0] root_of(sfeg_pkg::s64_t x, logic [63:0] s);
    logic [63:0] ux, xx, ss, v, r, c;
    ux = absval(x);
    if (ux > 64'hFFFF_FFFF) ux = 64'hFFFF_FFFF;
    xx = ux * ux;
    ss = s * s;
    v  = (xx > ~ss) ? '1 : xx + ss;
    r  = 0;
    for (int bitn = 31; bitn >= 0; bitn--) begin
      c = r | (64'd1 << bitn);
      if (c * c <= v) r = c;
    end
    return r[31:0];
  endfunction

  function automatic logic [63:0] sigma_eff();
    return (cur_sig == 0) ? 64'd1 : 64'(cur_sig);
  endfunction

  function automatic void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      sfeg_pkg::REG_SLOPE_B:   cur_b = val[30:0];
      sfeg_pkg::REG_SKEW_RHO:  cur_rho = val[29:0];
      sfeg_pkg::REG_SHIFT_M:   cur_m = val;
      sfeg_pkg::REG_SIGMA:     cur_sig = val[30:0];
      sfeg_pkg::REG_ATM_VAR:   cur_atm = val[30:0];
      sfeg_pkg::REG_WANT_GRAD: cur_grad = val[0];
      default:                 return;
    endcase
    cur_r0 = root_of(sfeg_pkg::s64_t'(cur_m), sigma_eff());
  endfunction

  // Fold one point into the sums; returns 1 with the totals on a last point
  function automatic bit fold_point(point_t p, output totals_t t);
    sfeg_pkg::s64_t k, wm, b, sig, r0, xi, rr, c0, brho, wk, res, r2;
    sfeg_pkg::s64_t r2b, tb, tm, inv_r, inv_r0, r2bs, gm_term;
    k    = sfeg_pkg::s64_t'(p.k);
    wm   = sfeg_pkg::s64_t'(p.wm);
    b    = sfeg_pkg::s64_t'({1'b0, cur_b});
    sig  = sfeg_pkg::s64_t'(sigma_eff());
    r0   = sfeg_pkg::s64_t'({32'd0, cur_r0});
    xi   = k - sfeg_pkg::s64_t'(cur_m);
    rr   = sfeg_pkg::s64_t'({32'd0, root_of(xi, 64'(sig))});
    c0   = qadd(sfeg_pkg::s64_t'({1'b0, cur_atm}), -qmul(b, r0, sfeg_pkg::FRAC_BITS));
    brho = qmul(b, sfeg_pkg::s64_t'(cur_rho), sfeg_pkg::FRAC_BITS);
    wk   = qadd(qadd(c0, qmul(brho, k, sfeg_pkg::FRAC_BITS)),
                qmul(b, rr, sfeg_pkg::FRAC_BITS));
    res  = qadd(wk, -wm);
    r2   = qadd(res, res);
    acc_sse = qadd(acc_sse, qmul(res, res, sfeg_pkg::QSH));
    if (cur_grad) begin
      r2b    = qmul(r2, b, sfeg_pkg::FRAC_BITS);
      tb     = qadd(qadd(qmul(sfeg_pkg::s64_t'(cur_rho), k, sfeg_pkg::FRAC_BITS), rr), -r0);
      tm     = qadd(qdiv(sfeg_pkg::s64_t'(cur_m), r0), qdiv(xi, rr));
      inv_r  = sfeg_pkg::s64_t'((64'd1 << (2 * sfeg_pkg::FRAC_BITS)) / rr);
      inv_r0 = sfeg_pkg::s64_t'((64'd1 << (2 * sfeg_pkg::FRAC_BITS)) / r0);
      r2bs   = qmul(r2, qmul(b, sig, sfeg_pkg::FRAC_BITS), sfeg_pkg::FRAC_BITS);
      gm_term = qmul(r2b, tm, sfeg_pkg::QSH);
      acc_gb   = qadd(acc_gb, qmul(r2, tb, sfeg_pkg::QSH));
      acc_grho = qadd(acc_grho, qmul(r2b, k, sfeg_pkg::QSH));
      acc_gm   = qadd(acc_gm, signed_sat(!gm_term[63], absval(gm_term)));
      acc_gs   = qadd(acc_gs, qmul(r2bs, inv_r - inv_r0, sfeg_pkg::QSH));
    end
    if (!p.last) return 1'b0;
    t.sse  = acc_sse[62:0];
    t.gb   = acc_gb;
    t.grho = acc_grho;
    t.gm   = acc_gm;
    t.gs   = acc_gs;
    acc_sse = 0; acc_gb = 0; acc_grho = 0; acc_gm = 0; acc_gs = 0;
    return 1'b1;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  // --------------------------------------------------------------------------
  // Point driver: changes at the falling edge, fed from pending_points
  // --------------------------------------------------------------------------
  logic in_taken = 1'b0;
  int   push_gap = 0;
  point_t next_pt;

  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!(push && !in_taken)) begin
      if (push_gap > 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (idle_en && $urandom_range(0, 19) == 0) begin
        push_gap = $urandom_range(0, 17);
        push <= 1'b0;
      end else if (pending_points.size() > 0) begin
        next_pt = pending_points.pop_front();
        push <= 1'b1;
        in_log_moneyness   <= next_pt.k;
        in_market_variance <= next_pt.wm;
        in_last_point      <= next_pt.last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Accepted points go through the predictor
  point_t  took_pt;
  totals_t took_tot;

  always @(posedge clk) begin
    in_taken <= push && !full;
    if (rst_n && push && !full) begin
      took_pt.k    = in_log_moneyness;
      took_pt.wm   = in_market_variance;
      took_pt.last = in_last_point;
      if (fold_point(took_pt, took_tot)) expected_totals.push_back(took_tot);
    end
  end

  // --------------------------------------------------------------------------
  // Result side: pop with random holds and one long hold on request
  // --------------------------------------------------------------------------
  int pop_hold = 0;
  int hold_seen = 0;

  always @(negedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      pop_hold  = LONG_HOLD;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (idle_en && $urandom_range(0, 15) == 0) begin
      pop_hold = $urandom_range(0, 17);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  totals_t want;

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_totals.size() == 0) begin
        report("unexpected result item", 64'(out_sum_sq_error), 64'd0);
      end else begin
        want = expected_totals.pop_front();
        if (out_sum_sq_error !== want.sse)
          report("sum_sq_error", 64'(out_sum_sq_error), 64'(want.sse));
        if (out_grad_b !== want.gb) report("grad_b", out_grad_b, want.gb);
        if (out_grad_rho !== want.grho) report("grad_rho", out_grad_rho, want.grho);
        if (out_grad_m !== want.gm) report("grad_m", out_grad_m, want.gm);
        if (out_grad_sigma !== want.gs) report("grad_sigma", out_grad_sigma, want.gs);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog on handshake activity
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TIMEOUT after %0d quiet cycles", quiet_cycles);
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= sfeg_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    set_reg(idx, val);
  endtask

  task automatic add_point(logic [31:0] k, logic [31:0] wm, logic last);
    point_t p;
    p.k = k;
    p.wm = wm;
    p.last = last;
    pending_points.push_back(p);
  endtask

  // wait for every queued point to go in and every result to come out
  task automatic drain();
    while (pending_points.size() > 0 || push) @(posedge clk);
    while (expected_totals.size() > 0) @(posedge clk);
    repeat (IDLE_DRAIN) @(posedge clk);
  endtask

  // mostly moderate values, with occasional extremes and raw words
  function automatic logic [31:0] pick_reg(logic [2:0] idx);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom;
    case (idx)
      sfeg_pkg::REG_SLOPE_B:
        return (sel == 1) ? 32'h7FFF_FFFF : $urandom_range(0, 1 << 28);
      sfeg_pkg::REG_SKEW_RHO:
        return (sel == 1) ? 32'(-(1 << 28)) :
                            32'($urandom_range(0, 1 << 29)) - 32'(1 << 28);
      sfeg_pkg::REG_SHIFT_M:
        return (sel == 1) ? 32'h8000_0000 :
                            32'($urandom_range(0, 1 << 28)) - 32'(1 << 27);
      sfeg_pkg::REG_SIGMA:
        return (sel == 1) ? 32'd0 : $urandom_range(1, 1 << 28);
      sfeg_pkg::REG_ATM_VAR:
        return (sel == 1) ? 32'h7FFF_FFFF : $urandom_range(0, 1 << 28);
      default:
        return $urandom_range(0, 3) != 0;
    endcase
  endfunction

  int smile_len, budget;
  bit wide;

  initial begin
    cur_b = 0; cur_rho = 0; cur_m = 0; cur_sig = 31'(1 << sfeg_pkg::FRAC_BITS); cur_atm = 0;
    cur_grad = 1'b1;
    cur_r0 = root_of(0, 64'(1 << sfeg_pkg::FRAC_BITS));
    acc_sse = 0; acc_gb = 0; acc_grho = 0; acc_gm = 0; acc_gs = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: field extremes
    add_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_point(32'd0, 32'd0, 1'b1);
    add_point(32'hFFFF_FFFF, 32'h1000_0000, 1'b0);
    add_point(32'h1000_0000, 32'h0800_0000, 1'b1);
    drain();

    // extremes of every register, gradient off, zero sigma, spare addresses
    write_reg(sfeg_pkg::REG_SLOPE_B, 32'h7FFF_FFFF);
    write_reg(sfeg_pkg::REG_SKEW_RHO, 32'(1 << 28));
    write_reg(sfeg_pkg::REG_SHIFT_M, 32'h8000_0000);
    write_reg(sfeg_pkg::REG_SIGMA, 32'd0);
    write_reg(sfeg_pkg::REG_ATM_VAR, 32'h7FFF_FFFF);
    write_reg(sfeg_pkg::REG_WANT_GRAD, 32'd0);
    write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_7, 32'h1234_5678);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    add_point(32'h0100_0000, 32'h0200_0000, 1'b1);
    drain();

    // opposite extremes, gradient back on, huge sigma
    write_reg(sfeg_pkg::REG_SKEW_RHO, 32'(-(1 << 28)));
    write_reg(sfeg_pkg::REG_SHIFT_M, 32'h7FFF_FFFF);
    write_reg(sfeg_pkg::REG_SIGMA, 32'h7FFF_FFFF);
    write_reg(sfeg_pkg::REG_WANT_GRAD, 32'd1);
    add_point(32'h8000_0000, 32'h8000_0000, 1'b0);
    add_point(32'h7FFF_FFFF, 32'd0, 1'b1);
    drain();

    // small sigma, zero slope, then moderate
    write_reg(sfeg_pkg::REG_SIGMA, 32'd1);
    write_reg(sfeg_pkg::REG_SLOPE_B, 32'd0);
    write_reg(sfeg_pkg::REG_SHIFT_M, 32'd0);
    add_point(32'd0, 32'd0, 1'b1);
    drain();
    write_reg(sfeg_pkg::REG_SLOPE_B, 32'(1 << 27));
    add_point(32'd0, 32'h0100_0000, 1'b0);
    add_point(32'hF000_0000, 32'h0400_0000, 1'b1);
    drain();

    // random phases of smiles
    for (int ph = 0; ph < NPHASES; ph++) begin
      if (ph >= NPHASES - 2) idle_en = 1'b0;
      for (int r = 0; r < 6; r++) begin
        if ($urandom_range(0, 2) != 0 || ph == 0) write_reg(3'(r), pick_reg(3'(r)));
      end
      if (ph % 4 == 1) write_reg(sfeg_pkg::REG_WANT_GRAD, 32'd0);
      if (ph == 3) hold_ask++;
      budget = 135;
      while (budget > 0) begin
        smile_len = $urandom_range(1, 8);
        if (smile_len > budget) smile_len = budget;
        wide = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < smile_len; i++) begin
          if (wide) begin
            add_point($urandom, $urandom, i == smile_len - 1);
          end else begin
            add_point(32'($urandom_range(0, 6 << 28)) - 32'(3 << 28),
                      32'($urandom_range(0, 1 << 29)) - 32'(1 << 26),
                      i == smile_len - 1);
          end
        end
        budget -= smile_len;
      end
      drain();
    end

    if (expected_totals.size() != 0) begin
      report("missing result items", 64'(expected_totals.size()), 64'd0);
    end
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
design/sfeg_pkg.sv
design/sfeg_front.sv
design/sfeg_mul.sv
design/sfeg_div.sv
design/sfeg_sqrt.sv
design/sfeg_back.sv
design/svi_fit_error_and_gradient.sv
dv/tb_top.sv
